// ----- rtl/pfb_pkg.sv -----
`default_nettype none
package pfb_pkg;
	localparam int FRAME_W_DEF = 128;
	localparam int FRAME_H_DEF = 64;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		ACT_BLIT  = 3'd0,
		ACT_WPIX  = 3'd1,
		ACT_RPIX  = 3'd2,
		ACT_CLR   = 3'd3,
		ACT_RBYTE = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_OR,
		OP_SETB,
		OP_CLRB,
		OP_RBIT,
		OP_ZERO,
		OP_RBYTE
	} op_t;

	// one memory access for the back end
	typedef struct packed {
		op_t        op;
		logic       hit;
		logic       last;
		logic [7:0] x;
		logic [4:0] page;
		logic [7:0] data;
		logic [2:0] bit_idx;
	} cmd_t;
endpackage
`default_nettype wire

// ----- rtl/pfb_ram.sv -----
`default_nettype none
module pfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/pfb_front.sv -----
`default_nettype none
module pfb_front #(
	parameter int FRAME_W = pfb_pkg::FRAME_W_DEF,
	parameter int FRAME_H = pfb_pkg::FRAME_H_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_take,
	input  wire logic [2:0]    action,
	input  wire logic [7:0]    dest_x,
	input  wire logic [7:0]    top_y,
	input  wire logic [4:0]    band,
	input  wire logic [7:0]    height,
	input  wire logic [7:0]    crop,
	input  wire logic [7:0]    pixel_byte,
	input  wire logic          invert,
	input  wire logic          point_on,
	input  wire logic [7:0]    anim_offset,
	output logic               busy,
	output logic               cmd_valid,
	output pfb_pkg::cmd_t      cmd,
	input  wire logic          cmd_ready
);
	localparam int PAGES = (FRAME_H + 7) / 8;
	localparam logic [8:0] W9 = 9'(FRAME_W);
	localparam logic [8:0] H9 = 9'(FRAME_H);
	localparam logic [8:0] P9 = 9'(PAGES);

	pfb_pkg::cmd_t a_c, b_c, second_q;
	logic has_second_q, a_valid;

	logic [7:0] yy, y, bottom, row, row_end, mask, pix, lo, hi, ywp;
	logic [2:0] shift;
	logic [3:0] sh_up;
	logic x_ok, band_ok, skip, put_a, put_b;
	logic [8:0] sl, sr;

	always_comb begin
		x_ok = {1'b0, dest_x} < W9;
		yy = top_y + anim_offset;
		y = yy - crop;
		bottom = yy + height;
		row = {band, 3'b000} + y;
		row_end = row + 8'd8;
		shift = y[2:0];
		band_ok = band < height[7:3];
		skip = (crop != 8'd0) && ((row_end < yy) || ({1'b0, row_end} > H9) || (row > bottom));
		sl = {1'b0, yy - row};
		sr = {1'b0, row_end - bottom};
		mask = 8'hFF;
		if (crop != 8'd0) begin
			if (row < yy) mask = (sl >= 9'd8) ? 8'd0 : 8'(8'hFF << sl[2:0]);
			else if (row_end > bottom) mask = (sr >= 9'd8) ? 8'd0 : 8'(8'hFF >> sr[2:0]);
		end
		pix = (invert ? ~pixel_byte : pixel_byte) & mask;
		lo = 8'(pix << shift);
		sh_up = 4'd8 - {1'b0, shift};
		hi = 8'(pix >> sh_up[2:0]);
		put_a = x_ok && band_ok && !skip && ({1'b0, row} < H9);
		put_b = x_ok && band_ok && !skip && (shift != 3'd0) && ({1'b0, row_end} < H9);
		ywp = top_y + anim_offset;

		a_c = '0;
		b_c = '0;
		a_c.x = dest_x;
		a_c.last = 1'b1;
		a_valid = 1'b1;
		b_c.x = dest_x;
		b_c.op = pfb_pkg::OP_OR;
		b_c.hit = 1'b1;
		b_c.last = 1'b1;
		b_c.page = row_end[7:3];
		b_c.data = hi;
		unique case (action)
			pfb_pkg::ACT_BLIT: begin
				a_c.page = row[7:3];
				a_c.data = lo;
				a_c.op = put_a ? pfb_pkg::OP_OR : pfb_pkg::OP_NONE;
				a_c.hit = put_a || put_b;
				a_c.last = !put_b;
			end
			pfb_pkg::ACT_WPIX: begin
				a_c.page = ywp[7:3];
				a_c.bit_idx = ywp[2:0];
				a_c.hit = x_ok && ({1'b0, ywp} < H9);
				a_c.op = !a_c.hit ? pfb_pkg::OP_NONE :
					(point_on ? pfb_pkg::OP_SETB : pfb_pkg::OP_CLRB);
			end
			pfb_pkg::ACT_RPIX: begin
				a_c.page = top_y[7:3];
				a_c.bit_idx = top_y[2:0];
				a_c.hit = x_ok && ({1'b0, top_y} < H9);
				a_c.op = a_c.hit ? pfb_pkg::OP_RBIT : pfb_pkg::OP_NONE;
			end
			pfb_pkg::ACT_CLR, pfb_pkg::ACT_RBYTE: begin
				a_c.page = top_y[7:3];
				a_c.hit = x_ok && ({4'd0, top_y[7:3]} < P9);
				a_c.op = !a_c.hit ? pfb_pkg::OP_NONE :
					(action == pfb_pkg::ACT_CLR ? pfb_pkg::OP_ZERO : pfb_pkg::OP_RBYTE);
			end
			default: a_c.op = pfb_pkg::OP_NONE;
		endcase
	end

	// small queue: a held command and an optional second one
	pfb_pkg::cmd_t hold_q;
	logic hold_v_q;
	assign cmd_valid = hold_v_q;
	assign cmd = hold_q;
	assign busy = hold_v_q || has_second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			has_second_q <= 1'b0;
		end else if (in_take) begin
			hold_v_q <= a_valid;
			hold_q <= a_c;
			has_second_q <= (action == pfb_pkg::ACT_BLIT) && put_b;
			second_q <= b_c;
		end else if (hold_v_q && cmd_ready) begin
			hold_v_q <= has_second_q;
			hold_q <= second_q;
			has_second_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/pfb_back.sv -----
`default_nettype none
module pfb_back #(
	parameter int FRAME_W = pfb_pkg::FRAME_W_DEF,
	parameter int FRAME_H = pfb_pkg::FRAME_H_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire pfb_pkg::cmd_t cmd,
	output logic               cmd_ready,
	output logic               done,
	output logic [7:0]         read_value,
	output logic               in_frame
);
	localparam int PAGES = (FRAME_H + 7) / 8;
	localparam int DEPTH = FRAME_W * PAGES;
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_RD, S_WR, S_CLR} state_t;
	state_t state_q;
	pfb_pkg::cmd_t c_q;
	logic [AW-1:0] addr_q, clr_q, raddr, waddr;
	logic [7:0] rdata, wdata, newb;
	logic we, acc_hit_q;
	logic [AW:0] addr_w;

	assign addr_w = (AW+1)'(cmd.x) + (AW+1)'(cmd.page) * (AW+1)'(FRAME_W);
	assign raddr = addr_w[AW-1:0];
	assign cmd_ready = (state_q == S_IDLE);

	always_comb begin
		unique case (c_q.op)
			pfb_pkg::OP_OR: newb = rdata | c_q.data;
			pfb_pkg::OP_SETB: newb = rdata | (8'd1 << c_q.bit_idx);
			pfb_pkg::OP_CLRB: newb = rdata & ~(8'd1 << c_q.bit_idx);
			pfb_pkg::OP_ZERO: newb = 8'd0;
			default: newb = rdata;
		endcase
		we = (state_q == S_CLR) || ((state_q == S_RD) && (c_q.op != pfb_pkg::OP_NONE));
		waddr = (state_q == S_CLR) ? clr_q : addr_q;
		wdata = (state_q == S_CLR) ? 8'd0 : newb;
	end

	pfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			done <= 1'b0;
			acc_hit_q <= 1'b0;
			in_frame <= 1'b0;
			read_value <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (cmd_valid) begin
					c_q <= cmd;
					addr_q <= raddr;
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_IDLE;
					if (c_q.last) begin
						done <= 1'b1;
						in_frame <= c_q.hit || acc_hit_q;
						acc_hit_q <= 1'b0;
						unique case (c_q.op)
							pfb_pkg::OP_RBIT: read_value <= {7'd0, rdata[c_q.bit_idx]};
							pfb_pkg::OP_RBYTE: read_value <= rdata;
							default: read_value <= 8'd0;
						endcase
					end else begin
						acc_hit_q <= c_q.hit;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(state_q) == S_RD);
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |=> state_q == S_IDLE);
	assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_frame |-> read_value == 8'd0);
endmodule
`default_nettype wire

// ----- rtl/page_framebuffer_bitmap_blit.sv -----
// channel | signals                                        | handshake
// cmd in  | action dest_x top_y band height crop ...       | start & !busy
// result  | read_value in_frame                             | done, one cycle
// config  | cfg_data (anim_offset)                          | cfg_valid & cfg_ready
// An item passes the front register, then the back end reads its RAM byte as it takes
// the command and writes the updated byte in S_RD; a blit across two pages adds a
// second access. The read-modify-write of the frame RAM sets the pace.
// After reset a clearing pass zeroes all FRAME_W*ceil(FRAME_H/8) bytes of the RAM;
// busy stays high until it ends. The receiver cannot stall; done pulses once.
`default_nettype none
module page_framebuffer_bitmap_blit #(
	parameter int FRAME_W = pfb_pkg::FRAME_W_DEF,
	parameter int FRAME_H = pfb_pkg::FRAME_H_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [2:0] action,
	input  wire logic [7:0] dest_x,
	input  wire logic [7:0] top_y,
	input  wire logic [4:0] band,
	input  wire logic [7:0] height,
	input  wire logic [7:0] crop,
	input  wire logic [7:0] pixel_byte,
	input  wire logic       invert,
	input  wire logic       point_on,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,
	output logic            done,
	output logic [7:0]      read_value,
	output logic            in_frame
);
	logic [7:0] anim_q;
	logic front_busy, cmd_valid, cmd_ready;
	pfb_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;
	assign busy = front_busy || !cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) anim_q <= '0;
		else if (cfg_valid) anim_q <= cfg_data;
	end

	pfb_front #(.FRAME_W(FRAME_W), .FRAME_H(FRAME_H)) u_front (
		.clk(clk), .arst_n(arst_n), .in_take(start && !busy),
		.action(action), .dest_x(dest_x), .top_y(top_y), .band(band),
		.height(height), .crop(crop), .pixel_byte(pixel_byte), .invert(invert),
		.point_on(point_on), .anim_offset(anim_q), .busy(front_busy),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready)
	);

	pfb_back #(.FRAME_W(FRAME_W), .FRAME_H(FRAME_H)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_ready(cmd_ready), .done(done), .read_value(read_value), .in_frame(in_frame)
	);
endmodule
`default_nettype wire

// ----- bench/page_framebuffer_bitmap_blit_test.sv -----
`default_nettype none
module page_framebuffer_bitmap_blit_test;
	localparam int FW = pfb_pkg::FRAME_W_DEF;
	localparam int FH = pfb_pkg::FRAME_H_DEF;
	localparam int PAGES = (FH + 7) / 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [7:0] read_value;
		logic       in_frame;
	} frame_result_t;

	typedef struct {
		pfb_pkg::action_t act;
		logic [7:0] x;
		logic [7:0] y;
		logic [4:0] band;
		logic [7:0] height;
		logic [7:0] crop;
		logic [7:0] pix;
		logic       invert;
		logic       point_on;
	} frame_cmd_t;

	class frame_scoreboard;
		logic [7:0]    shadow [FW*PAGES];
		logic [7:0]    offset;
		frame_result_t pending [$];
		int            errors;
		int            checked;

		function void clear_all();
			foreach (shadow[i]) shadow[i] = 8'h00;
			offset = 8'h00;
			pending.delete();
			errors = 0;
			checked = 0;
		endfunction

		function logic [7:0] shl(logic [7:0] v, int s);
			return (s >= 8) ? 8'h00 : 8'(v << s);
		endfunction

		function logic [7:0] shr(logic [7:0] v, int s);
			return (s >= 8) ? 8'h00 : 8'(v >> s);
		endfunction

		function logic blit(frame_cmd_t c);
			logic [7:0] yy, yc, bottom, row, row_end, mask, p;
			int shift;
			logic hit;
			hit = 1'b0;
			if (c.band >= c.height / 8 || c.x >= FW) return 1'b0;
			yy = c.y + offset;
			yc = yy - c.crop;
			bottom = yy + c.height;
			row = {c.band, 3'b000} + yc;
			row_end = row + 8'd8;
			shift = yc[2:0];
			mask = 8'hFF;
			if (c.crop != 0) begin
				if (row_end < yy || row_end > FH || row > bottom) return 1'b0;
				if (row < yy) mask = shl(8'hFF, yy - row);
				else if (row_end > bottom) mask = shr(8'hFF, row_end - bottom);
			end
			p = c.invert ? ~c.pix : c.pix;
			p &= mask;
			if (row < FH) begin
				shadow[c.x + (row / 8) * FW] |= shl(p, shift);
				hit = 1'b1;
			end
			if (shift != 0 && row_end < FH) begin
				shadow[c.x + (row_end / 8) * FW] |= shr(p, 8 - shift);
				hit = 1'b1;
			end
			return hit;
		endfunction

		function void note_item(frame_cmd_t c);
			frame_result_t r;
			logic [7:0] yy;
			int a;
			r.read_value = 8'h00;
			r.in_frame = 1'b0;
			a = c.x + (c.y / 8) * FW;
			case (c.act)
				pfb_pkg::ACT_BLIT: r.in_frame = blit(c);
				pfb_pkg::ACT_WPIX: begin
					yy = c.y + offset;
					if (yy < FH && c.x < FW) begin
						a = c.x + (yy / 8) * FW;
						if (c.point_on) shadow[a][yy[2:0]] = 1'b1;
						else shadow[a][yy[2:0]] = 1'b0;
						r.in_frame = 1'b1;
					end
				end
				pfb_pkg::ACT_RPIX: if (c.y < FH && c.x < FW) begin
					r.read_value = {7'd0, shadow[a][c.y[2:0]]};
					r.in_frame = 1'b1;
				end
				pfb_pkg::ACT_CLR: if (c.x < FW && c.y / 8 < PAGES) begin
					shadow[a] = 8'h00;
					r.in_frame = 1'b1;
				end
				pfb_pkg::ACT_RBYTE: if (c.x < FW && c.y / 8 < PAGES) begin
					r.read_value = shadow[a];
					r.in_frame = 1'b1;
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		task report(string what);
			errors++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_result(logic [7:0] rv, logic inf);
			frame_result_t e;
			checked++;
			if (pending.size() == 0) begin
				report("result with nothing pending");
				return;
			end
			e = pending.pop_front();
			if (rv !== e.read_value)
				report($sformatf("read_value %h, want %h", rv, e.read_value));
			if (inf !== e.in_frame)
				report($sformatf("in_frame %b, want %b", inf, e.in_frame));
		endtask
	endclass

	logic       clk, arst_n, start, busy, cfg_valid, cfg_ready, done, in_frame;
	logic [2:0] action;
	logic [7:0] dest_x, top_y, height, crop, pixel_byte, cfg_data, read_value;
	logic [4:0] band;
	logic       invert, point_on;

	frame_scoreboard board;
	int cycles;
	int idle_pct;
	int items_sent;

	page_framebuffer_bitmap_blit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .dest_x(dest_x), .top_y(top_y), .band(band),
		.height(height), .crop(crop), .pixel_byte(pixel_byte),
		.invert(invert), .point_on(point_on), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done),
		.read_value(read_value), .in_frame(in_frame)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	always @(posedge clk) begin
		cycles++;
		if (arst_n && done) board.check_result(read_value, in_frame);
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// start stays high after an accept until the next call or a drain lowers it
	task send_item(frame_cmd_t c);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		action <= c.act;
		dest_x <= c.x;
		top_y <= c.y;
		band <= c.band;
		height <= c.height;
		crop <= c.crop;
		pixel_byte <= c.pix;
		invert <= c.invert;
		point_on <= c.point_on;
		do @(posedge clk); while (busy);
		board.note_item(c);
		items_sent++;
		@(negedge clk);
	endtask

	task drain();
		start <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task write_offset(logic [7:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		board.offset = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function frame_cmd_t random_cmd();
		frame_cmd_t c;
		int k;
		k = $urandom_range(99);
		c.act = pfb_pkg::action_t'(k < 45 ? 0 : k < 60 ? 1 : k < 72 ? 2 : k < 80 ? 3 :
			k < 97 ? 4 : $urandom_range(5, 7));
		c.x = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(FW - 1));
		c.y = ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(FH + 7));
		c.band = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(3));
		c.height = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8, 40));
		c.crop = ($urandom_range(1) == 0) ? 8'h00 :
			($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 15));
		c.pix = 8'($urandom);
		c.invert = 1'($urandom);
		c.point_on = 1'($urandom);
		return c;
	endfunction

	function frame_cmd_t mk(pfb_pkg::action_t a, logic [7:0] x, logic [7:0] y,
			logic [4:0] b, logic [7:0] h, logic [7:0] cr, logic [7:0] p, logic inv,
			logic on);
		frame_cmd_t c;
		c.act = a; c.x = x; c.y = y; c.band = b; c.height = h;
		c.crop = cr; c.pix = p; c.invert = inv; c.point_on = on;
		return c;
	endfunction

	initial begin
		frame_cmd_t c;
		board = new();
		board.clear_all();
		cycles = 0;
		items_sent = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 8'h00;
		action = pfb_pkg::ACT_BLIT;
		dest_x = 8'h00; top_y = 8'h00; band = 5'd0; height = 8'h00;
		crop = 8'h00; pixel_byte = 8'h00; invert = 1'b0; point_on = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: edges, every action, clipping and masking cases
		send_item(mk(pfb_pkg::ACT_BLIT, 8'd0, 8'd0, 5'd0, 8'd8, 8'd0, 8'hA5, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_BLIT, 8'd127, 8'd60, 5'd0, 8'd8, 8'd0, 8'hFF, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_BLIT, 8'd5, 8'd3, 5'd1, 8'd16, 8'd0, 8'h0F, 1'b1, 1'b0));
		send_item(mk(pfb_pkg::ACT_BLIT, 8'd128, 8'd0, 5'd0, 8'd8, 8'd0, 8'hFF, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_BLIT, 8'd255, 8'd0, 5'd0, 8'd8, 8'd0, 8'hFF, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_BLIT, 8'd9, 8'd0, 5'd1, 8'd8, 8'd0, 8'hFF, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_BLIT, 8'd10, 8'd250, 5'd0, 8'd16, 8'd0, 8'hFF, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_BLIT, 8'd11, 8'd20, 5'd0, 8'd12, 8'd3, 8'hFF, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_BLIT, 8'd12, 8'd20, 5'd1, 8'd12, 8'd5, 8'hFF, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_BLIT, 8'd13, 8'd60, 5'd0, 8'd8, 8'd1, 8'hFF, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_BLIT, 8'd14, 8'd8, 5'd31, 8'd255, 8'd255, 8'h3C, 1'b1,
			1'b0));
		send_item(mk(pfb_pkg::ACT_WPIX, 8'd0, 8'd0, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
		send_item(mk(pfb_pkg::ACT_WPIX, 8'd127, 8'd63, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
		send_item(mk(pfb_pkg::ACT_WPIX, 8'd127, 8'd64, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
		send_item(mk(pfb_pkg::ACT_WPIX, 8'd0, 8'd0, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_RPIX, 8'd127, 8'd63, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_RPIX, 8'd0, 8'd255, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_RBYTE, 8'd0, 8'd0, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_RBYTE, 8'd127, 8'd56, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_RBYTE, 8'd200, 8'd64, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_CLR, 8'd127, 8'd56, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::ACT_CLR, 8'd0, 8'd255, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
		send_item(mk(pfb_pkg::action_t'(3'd7), 8'd1, 8'd1, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0,
			1'b0));

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_offset(8'd0);
				1: write_offset(8'd255);
				2: write_offset(8'd7);
				3: write_offset(8'($urandom));
				4: write_offset(8'd200);
				default: write_offset(8'd0);
			endcase
			idle_pct = (phase < 2) ? 9 : (phase < 4) ? 60 : 0;
			for (int n = 0; n < 235; n++) begin
				c = random_cmd();
				send_item(c);
			end
		end

		drain();
		$display("%0d items sent, %0d results checked, offsets 0/7/200/255 and random",
			items_sent, board.checked);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d errors, %0d left pending", board.errors, board.pending.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire
